/* src/srca_pkg.sv */
package srca_pkg;

  // request codes
  localparam logic [2:0] REQ_SEED   = 3'd0;
  localparam logic [2:0] REQ_NEXT   = 3'd1;
  localparam logic [2:0] REQ_CANARY = 3'd2;
  localparam logic [2:0] REQ_CHECK  = 3'd3;
  localparam logic [2:0] REQ_USER   = 3'd4;
  localparam logic [2:0] REQ_KERNEL = 3'd5;

  // multiplier partial product steps
  localparam logic [1:0] MSTEP_LL = 2'd0;
  localparam logic [1:0] MSTEP_LH = 2'd1;
  localparam logic [1:0] MSTEP_HL = 2'd2;

  localparam logic [63:0] MIX_MUL_A         = 64'hFF51AFD7ED558CCD;
  localparam logic [63:0] MIX_MUL_B         = 64'hC4CEB9FE1A85EC53;
  localparam logic [63:0] USER_BASE         = 64'h0000000000400000;
  localparam logic [63:0] KERNEL_BASE       = 64'hFFFFFFFF80000000;
  localparam logic [19:0] PAGE_FIELD_MASK   = 20'hFFFFF;
  localparam logic [63:0] CANARY_TERMINATOR = 64'h00FF0A0000000000;
  localparam logic [63:0] KERNEL_IMAGE_TAG  = 64'h00000000C0DEF00D;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        ok;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       sel_b;
    logic       xs_load;
    logic       finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_mix;
  } sts_t;

endpackage

/* src/srca_datapath.sv */
module srca_datapath
  import srca_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  req_t in_data,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t out_data
);

  logic [2:0]  req_type_q;
  logic [63:0] a_q;
  logic [63:0] b_q;
  logic [63:0] v;
  logic [63:0] acc;
  logic [63:0] random_state;
  logic        random_seeded;
  logic [63:0] canary_value;
  logic        canary_valid;

  logic [63:0] mix_in;
  logic [63:0] mul_k;
  logic [31:0] x_half;
  logic [31:0] k_half;
  logic [63:0] prod;
  logic [63:0] acc_xs;
  logic [63:0] xs_a;
  logic [63:0] xs_b;
  logic [63:0] xs_c;
  logic [63:0] page_off;
  logic [63:0] canary_new;

  logic [63:0] random_state_next;
  logic        random_seeded_next;
  logic [63:0] canary_value_next;
  logic        canary_valid_next;
  rsp_t        rsp_next;

  // fmix input and whether the request needs it
  always_comb begin
    unique case (in_data.req_type)
      REQ_USER:   mix_in = in_data.operand_a ^ in_data.operand_b;
      REQ_KERNEL: mix_in = in_data.operand_a ^ KERNEL_IMAGE_TAG;
      default:    mix_in = in_data.operand_a;
    endcase
    sts.need_mix = (in_data.req_type == REQ_USER) || (in_data.req_type == REQ_KERNEL)
                || ((in_data.req_type == REQ_SEED) && (in_data.operand_a != '0));
  end

  // one 32x32 multiplier, low 64 bits built from three partial products
  always_comb begin
    mul_k = cmd.sel_b ? MIX_MUL_B : MIX_MUL_A;
    unique case (cmd.mul_step)
      MSTEP_LL: begin
        x_half = v[31:0];
        k_half = mul_k[31:0];
      end
      MSTEP_LH: begin
        x_half = v[31:0];
        k_half = mul_k[63:32];
      end
      MSTEP_HL: begin
        x_half = v[63:32];
        k_half = mul_k[31:0];
      end
      default: begin
        x_half = '0;
        k_half = '0;
      end
    endcase
    prod   = {32'b0, x_half} * {32'b0, k_half};
    acc_xs = acc ^ (acc >> 33);
  end

  // request completion
  always_comb begin
    xs_a       = random_state ^ (random_state << 13);
    xs_b       = xs_a ^ (xs_a >> 7);
    xs_c       = xs_b ^ (xs_b << 17);
    page_off   = {32'b0, acc_xs[19:0] & PAGE_FIELD_MASK, 12'b0};
    canary_new = (xs_c ^ a_q) | CANARY_TERMINATOR;

    random_state_next  = random_state;
    random_seeded_next = random_seeded;
    canary_value_next  = canary_value;
    canary_valid_next  = canary_valid;
    rsp_next           = '0;

    unique case (req_type_q)
      REQ_SEED: begin
        if (a_q != '0) begin
          random_state_next  = acc_xs;
          random_seeded_next = (acc_xs != '0);
          rsp_next.ok        = (acc_xs != '0);
        end
      end
      REQ_NEXT: begin
        if (random_seeded) begin
          random_state_next     = xs_c;
          rsp_next.result_value = xs_c;
          rsp_next.ok           = 1'b1;
        end
      end
      REQ_CANARY: begin
        if (random_seeded) begin
          random_state_next = xs_c;
          if ((xs_c != '0) && (a_q != '0)) begin
            canary_value_next     = canary_new;
            canary_valid_next     = 1'b1;
            rsp_next.result_value = canary_new;
            rsp_next.ok           = 1'b1;
          end
        end
      end
      REQ_CHECK: begin
        rsp_next.ok = canary_valid && (a_q == b_q) && (b_q == canary_value);
      end
      REQ_USER: begin
        rsp_next.result_value = USER_BASE + page_off;
        rsp_next.ok           = 1'b1;
      end
      REQ_KERNEL: begin
        rsp_next.result_value = KERNEL_BASE + page_off;
        rsp_next.ok           = 1'b1;
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_q <= in_data.req_type;
      a_q        <= in_data.operand_a;
      b_q        <= in_data.operand_b;
      v          <= mix_in ^ (mix_in >> 33);
    end else if (cmd.xs_load) begin
      v <= acc_xs;
    end
    if (cmd.mul_en) begin
      if (cmd.mul_step == MSTEP_LL) begin
        acc <= prod;
      end else begin
        acc <= acc + {prod[31:0], 32'b0};
      end
    end
    if (cmd.finish) begin
      out_data <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      random_state  <= '0;
      random_seeded <= 1'b0;
      canary_value  <= '0;
      canary_valid  <= 1'b0;
    end else if (cmd.finish) begin
      random_state  <= random_state_next;
      random_seeded <= random_seeded_next;
      canary_value  <= canary_value_next;
      canary_valid  <= canary_valid_next;
    end
  end

endmodule

/* src/srca_ctrl.sv */
module srca_ctrl
  import srca_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MA0,
    S_MA1,
    S_MA2,
    S_XS,
    S_MB0,
    S_MB1,
    S_MB2,
    S_FIN
  } state_t;

  state_t state;
  logic   accept;
  logic   fin_go;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    cmd         = '0;
    cmd.load    = accept;
    cmd.finish  = fin_go;
    unique case (state)
      S_MA0: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MSTEP_LL;
      end
      S_MA1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MSTEP_LH;
      end
      S_MA2: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MSTEP_HL;
      end
      S_XS: begin
        cmd.xs_load = 1'b1;
      end
      S_MB0: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MSTEP_LL;
        cmd.sel_b    = 1'b1;
      end
      S_MB1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MSTEP_LH;
        cmd.sel_b    = 1'b1;
      end
      S_MB2: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MSTEP_HL;
        cmd.sel_b    = 1'b1;
      end
      default: begin
        cmd.mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= sts.need_mix ? S_MA0 : S_FIN;
          end
        end
        S_MA0: state <= S_MA1;
        S_MA1: state <= S_MA2;
        S_MA2: state <= S_XS;
        S_XS:  state <= S_MB0;
        S_MB0: state <= S_MB1;
        S_MB1: state <= S_MB2;
        S_MB2: state <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/seeded_random_canary_aslr_engine.sv */
// channel   beat     signals                       payload
// request   in       in_valid, in_ready, in_data   req_type, operand_a, operand_b
// response  out      out_valid, out_ready, out_data result_value, ok
//
// non-zero seed, user aslr and kernel aslr beats have their response loaded into
// the output register after the MA0-MA2, XS and MB0-MB2 states, which run the
// two fmix64 multiplies sharing one 32x32 multiplier (three partial products
// each); every other beat, a zero seed included, goes from idle to S_FIN
// no new beat is taken before the current response is loaded
// rst is synchronous: generator unseeded, no canary, no response pending
// a finished response is held in the output register while out_ready is low;
// the next request is taken as soon as the engine returns to idle
module seeded_random_canary_aslr_engine
  import srca_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: mix steps, multiplier schedule and response handshake
  srca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: generator state, canary store, fmix64 and response register
  srca_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

/* dv/entropy_engine_monitor.sv */
`timescale 1ns / 100ps

module entropy_engine_monitor
  import srca_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  req_t        in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  rsp_t        out_data,
  output int          answer_mismatches,
  output int          answers_pending,
  output logic [63:0] canary_now
);

  // own copy of the engine state
  logic [63:0] gen_state;
  logic        gen_seeded;
  logic [63:0] stored_canary;
  logic        canary_set;

  rsp_t pending_answers[$];

  function automatic logic [63:0] avalanche64(input logic [63:0] v);
    logic [63:0] x;
    x = v;
    x = x ^ (x >> 33);
    x = x * MIX_MUL_A;
    x = x ^ (x >> 33);
    x = x * MIX_MUL_B;
    x = x ^ (x >> 33);
    return x;
  endfunction

  function automatic logic [63:0] xorshift_step(input logic [63:0] v);
    logic [63:0] x;
    x = v;
    x = x ^ (x << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 17);
    return x;
  endfunction

  // 20-bit page number from the mix, shifted up to a page address
  function automatic logic [63:0] aslr_offset(input logic [63:0] mixin);
    logic [63:0] mix;
    mix = avalanche64(mixin);
    return {32'd0, mix[19:0] & PAGE_FIELD_MASK, 12'd0};
  endfunction

  // works out the response and advances the state, one call per request beat
  function automatic rsp_t engine_answer(input req_t r);
    rsp_t        ans;
    logic [63:0] word;
    ans  = '0;
    word = '0;
    case (r.req_type)
      REQ_SEED: begin
        if (r.operand_a != 64'd0) begin
          gen_state  = avalanche64(r.operand_a);
          gen_seeded = (gen_state != 64'd0);
          ans.ok     = gen_seeded;
        end
      end
      REQ_NEXT: begin
        if (gen_seeded) begin
          gen_state        = xorshift_step(gen_state);
          ans.result_value = gen_state;
          ans.ok           = 1'b1;
        end
      end
      REQ_CANARY: begin
        // the generator steps even when the canary is refused
        if (gen_seeded) begin
          gen_state = xorshift_step(gen_state);
          word      = gen_state;
        end
        if (word != 64'd0 && r.operand_a != 64'd0) begin
          stored_canary    = (word ^ r.operand_a) | CANARY_TERMINATOR;
          canary_set       = 1'b1;
          ans.result_value = stored_canary;
          ans.ok           = 1'b1;
        end
      end
      REQ_CHECK: begin
        ans.ok = canary_set && (r.operand_a == r.operand_b) &&
                 (r.operand_b == stored_canary);
      end
      REQ_USER: begin
        ans.result_value = USER_BASE + aslr_offset(r.operand_a ^ r.operand_b);
        ans.ok           = 1'b1;
      end
      REQ_KERNEL: begin
        ans.result_value = KERNEL_BASE + aslr_offset(KERNEL_IMAGE_TAG ^ r.operand_a);
        ans.ok           = 1'b1;
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
    answer_mismatches = answer_mismatches + 1;
    if (answer_mismatches <= 10)
      $display("%0t mismatch (%s): expected value %h ok %b, got value %h ok %b",
               $realtime, what, want.result_value, want.ok, got.result_value, got.ok);
  endtask

  initial begin
    answer_mismatches = 0;
    answers_pending   = 0;
    canary_now        = '0;
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      gen_state     = '0;
      gen_seeded    = 1'b0;
      stored_canary = '0;
      canary_set    = 1'b0;
      pending_answers.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_answers.size() == 0) begin
          note_mismatch("response beat with nothing outstanding", '0, out_data);
        end else begin
          want = pending_answers.pop_front();
          if (out_data.result_value !== want.result_value)
            note_mismatch("result_value", want, out_data);
          else if (out_data.ok !== want.ok)
            note_mismatch("ok", want, out_data);
        end
      end
      if (in_valid && in_ready)
        pending_answers.push_back(engine_answer(in_data));
    end
    answers_pending = pending_answers.size();
    canary_now      = stored_canary;
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import srca_pkg::*;

  // the two request codes the engine ignores
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;
  localparam int BLOCK_BEATS   = 115;
  localparam int RANDOM_BLOCKS = 10;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  req_t        in_data;
  logic        out_valid;
  logic        out_ready;
  rsp_t        out_data;

  int          answer_mismatches;
  int          answers_pending;
  logic [63:0] canary_now;
  int          cycle_count;

  // shared with the response-side process
  bit          steady;     // no idling on either side for the current block
  bit          long_hold;  // ask the receiver for one long hold-off

  seeded_random_canary_aslr_engine dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  entropy_engine_monitor monitor (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .answer_mismatches(answer_mismatches),
    .answers_pending  (answers_pending),
    .canary_now       (canary_now)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog, generous against the slowest legal run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // operand with a bias towards zero, all ones and walking bit patterns
  function automatic logic [63:0] rand_operand();
    int          pick;
    logic [63:0] onehot;
    pick   = $urandom_range(0, 15);
    onehot = 64'd1 << $urandom_range(0, 63);
    case (pick)
      0:       return '0;
      1:       return '1;
      2:       return onehot;
      3:       return ~onehot;
      default: return rand_word();
    endcase
  endfunction

  // idle cycles before the next beat: mostly none, some short, a few long
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 60)
      return 0;
    else if (pick < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(5, 30);
  endfunction

  function automatic req_t make_req(input logic [2:0] kind, input logic [63:0] a,
                                    input logic [63:0] b);
    req_t r;
    r.req_type  = kind;
    r.operand_a = a;
    r.operand_b = b;
    return r;
  endfunction

  // weighted request mix; checks mostly aim at the live canary so they can pass
  function automatic req_t random_req();
    req_t r;
    int   pick;
    int   sub;
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 9);
    r    = make_req(REQ_NEXT, rand_operand(), rand_operand());
    if (pick < 10) begin
      r.req_type = REQ_SEED;
    end else if (pick < 35) begin
      r.req_type = REQ_NEXT;
    end else if (pick < 55) begin
      r.req_type = REQ_CANARY;
      if (sub == 0)
        r.operand_a = '0;
    end else if (pick < 75) begin
      r.req_type = REQ_CHECK;
      if (sub < 5) begin
        r.operand_a = canary_now;
        r.operand_b = canary_now;
      end else if (sub == 5) begin
        r.operand_a = canary_now;
      end else if (sub == 6) begin
        r.operand_b = canary_now;
      end else if (sub == 7) begin
        r.operand_b = r.operand_a;
      end
    end else if (pick < 85) begin
      r.req_type = REQ_USER;
    end else if (pick < 95) begin
      r.req_type = REQ_KERNEL;
    end else begin
      r.req_type = (pick < 97) ? REQ_SPARE_LO : REQ_SPARE_HI;
    end
    return r;
  endfunction

  // entered and left at a falling edge; valid stays up after the beat so that
  // a back-to-back beat never drops and raises it in one step
  task automatic send_beat(input req_t beat, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // sender stops until every outstanding response has come back
  task automatic drain_responses();
    in_valid <= 1'b0;
    wait (answers_pending == 0);
    @(negedge clk);
  endtask

  // response side: random stalls, plus one long hold-off on request
  initial begin
    int pick;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (long_hold) begin
        // long enough for the engine to back up and drop in_ready
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (pick < 95 ? $urandom_range(0, 2) : $urandom_range(10, 40))
            @(negedge clk);
        end
      end
    end
  end

  // request side and verdict
  initial begin
    int   blk;
    int   counted;
    req_t beat;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    steady    = 1'b0;
    long_hold = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: unseeded generator, no canary yet, zero seed
    send_beat(make_req(REQ_NEXT, '0, '0), idle_gap());
    send_beat(make_req(REQ_CANARY, '1, '1), idle_gap());
    send_beat(make_req(REQ_CHECK, '0, '0), idle_gap());
    send_beat(make_req(REQ_SEED, '0, '1), idle_gap());
    // aslr operand extremes; kernel tag as image id mixes from zero
    send_beat(make_req(REQ_USER, '0, '0), idle_gap());
    send_beat(make_req(REQ_USER, '1, '0), idle_gap());
    send_beat(make_req(REQ_USER, '0, '1), idle_gap());
    send_beat(make_req(REQ_KERNEL, '0, '1), idle_gap());
    send_beat(make_req(REQ_KERNEL, '1, '0), idle_gap());
    send_beat(make_req(REQ_KERNEL, KERNEL_IMAGE_TAG, '0), idle_gap());
    // ignored request codes
    send_beat(make_req(REQ_SPARE_LO, '1, '1), idle_gap());
    send_beat(make_req(REQ_SPARE_HI, '1, '1), idle_gap());
    // seeded paths, zero thread id still steps the generator
    send_beat(make_req(REQ_SEED, '1, '0), idle_gap());
    send_beat(make_req(REQ_NEXT, '1, '1), idle_gap());
    send_beat(make_req(REQ_CANARY, '0, '0), idle_gap());
    send_beat(make_req(REQ_CANARY, '1, '0), idle_gap());
    // canary checks: full match, and each operand alone matching
    send_beat(make_req(REQ_CHECK, canary_now, canary_now), idle_gap());
    send_beat(make_req(REQ_CHECK, canary_now, ~canary_now), idle_gap());
    send_beat(make_req(REQ_CHECK, ~canary_now, canary_now), idle_gap());
    send_beat(make_req(REQ_CHECK, '1, '1), idle_gap());
    send_beat(make_req(REQ_SEED, 64'd1, '1), idle_gap());
    send_beat(make_req(REQ_NEXT, '0, '0), idle_gap());
    send_beat(make_req(REQ_CANARY, 64'd1, '1), idle_gap());
    send_beat(make_req(REQ_CHECK, canary_now, canary_now), idle_gap());

    // random blocks; ignored codes are not counted towards a block
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      steady = ($urandom_range(0, 3) == 0);
      if (blk == 5 || $urandom_range(0, 3) == 0)
        drain_responses();
      if (blk == 2) begin
        // back-pressure: receiver holds off while beats keep coming
        steady    = 1'b1;
        long_hold = 1'b1;
      end
      counted = 0;
      while (counted < BLOCK_BEATS) begin
        beat = random_req();
        send_beat(beat, idle_gap());
        if (beat.req_type <= REQ_KERNEL)
          counted++;
      end
    end

    steady = 1'b0;
    drain_responses();
    repeat (30) @(posedge clk);
    if (answer_mismatches == 0 && answers_pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
